// File: sv/lbf_pkg.sv
// Shared types and codes of the learning bridge forwarder.
`timescale 1ns / 1ps

package lbf_pkg;

  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_BCAST   = 2'd1;
  localparam logic [1:0] ACT_UNKNOWN = 2'd2;
  localparam logic [1:0] ACT_FILTER  = 2'd3;

  typedef struct packed {
    logic cap;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic last_issue;
  } status_t;

endpackage

// File: sv/lbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lbf_ctrl.sv
// Controller state machine of the learning bridge forwarder.
`timescale 1ns / 1ps

module lbf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  lbf_pkg::status_t status,
  output lbf_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.cap    = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = status.cnt_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/lbf_dp.sv
// Datapath of the learning bridge forwarder: address table, scan compare and result register.
`timescale 1ns / 1ps

module lbf_dp #(
  parameter int ADDR_BITS   = 48,
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbf_pkg::cmd_t        cmd,
  output lbf_pkg::status_t     status,
  input  logic [ADDR_BITS-1:0] in_dest_addr,
  input  logic [ADDR_BITS-1:0] in_src_addr,
  input  logic                 in_arrival_port,
  output logic [1:0]           out_action,
  output logic                 out_port,
  output logic                 out_learned,
  output logic                 out_table_full
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  logic [ADDR_BITS-1:0] dst_r;
  logic [ADDR_BITS-1:0] src_r;
  logic                 port_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 cmp_en_r;
  logic                 src_hit_r;
  logic                 dst_hit_r;
  logic                 dst_port_r;
  logic [1:0]           act_r;
  logic                 oport_r;
  logic                 learned_r;
  logic                 full_r;

  logic [ADDR_BITS:0]   rdata;
  logic                 we;
  logic                 tbl_full;
  logic                 learn;
  logic [1:0]           act_nxt;
  logic                 oport_nxt;

  assign tbl_full = (cnt_r == FULL_CNT);
  assign learn    = !src_hit_r && !tbl_full;
  assign we       = cmd.finish && learn;

  assign status.cnt_zero   = (cnt_r == '0);
  assign status.last_issue = ((CNT_W'(idx_r) + 1'b1) == cnt_r);

  lbf_ram #(
    .WIDTH (ADDR_BITS + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({port_r, src_r}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    act_nxt   = lbf_pkg::ACT_UNKNOWN;
    oport_nxt = 1'b0;
    if (&dst_r) begin
      act_nxt = lbf_pkg::ACT_BCAST;
    end else if (dst_hit_r) begin
      if (dst_port_r == port_r) begin
        act_nxt = lbf_pkg::ACT_FILTER;
      end else begin
        act_nxt   = lbf_pkg::ACT_FORWARD;
        oport_nxt = dst_port_r;
      end
    end else if (learn && (dst_r == src_r)) begin
      act_nxt = lbf_pkg::ACT_FILTER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      dst_r  <= in_dest_addr;
      src_r  <= in_src_addr;
      port_r <= in_arrival_port;
    end
    if (cmp_en_r && (rdata[ADDR_BITS-1:0] == dst_r)) begin
      dst_port_r <= rdata[ADDR_BITS];
    end
    if (cmd.finish) begin
      act_r     <= act_nxt;
      oport_r   <= oport_nxt;
      learned_r <= learn;
      full_r    <= !src_hit_r && tbl_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cnt_r     <= '0;
      cmp_en_r  <= 1'b0;
      src_hit_r <= 1'b0;
      dst_hit_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.issue;
      if (cmd.cap) begin
        idx_r     <= '0;
        src_hit_r <= 1'b0;
        dst_hit_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (cmp_en_r) begin
          if (rdata[ADDR_BITS-1:0] == src_r) begin
            src_hit_r <= 1'b1;
          end
          if (rdata[ADDR_BITS-1:0] == dst_r) begin
            dst_hit_r <= 1'b1;
          end
        end
      end
      if (we) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign out_action     = act_r;
  assign out_port       = oport_r;
  assign out_learned    = learned_r;
  assign out_table_full = full_r;

endmodule

// File: sv/learning_bridge_forwarder.sv
// Top level of the two-port transparent learning bridge forwarder.
`timescale 1ns / 1ps

// Each item is one frame header; the block learns its source address into a table of
// TABLE_DEPTH entries, filled in order and never aged, and then gives one result with
// the forwarding decision. Both the source and the destination lookups are made in a
// single scan of the table memory, one stored entry per cycle. The item is captured,
// each stored entry is read and compared, and then the result is registered; while
// the table is empty the scan is skipped. No new item is taken while one is in work;
// a new item is accepted once the previous one has been moved into the output
// register, even while that result still waits.
// No clearing pass is needed after reset: the fill count marks which entries are valid.

module learning_bridge_forwarder #(
  parameter int ADDR_BITS   = 48,
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADDR_BITS-1:0] in_dest_addr,
  input  logic [ADDR_BITS-1:0] in_src_addr,
  input  logic                 in_arrival_port,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_action,
  output logic                 out_port,
  output logic                 out_learned,
  output logic                 out_table_full
);

  lbf_pkg::cmd_t    cmd;
  lbf_pkg::status_t status;

  lbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lbf_dp #(
    .ADDR_BITS   (ADDR_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_dest_addr    (in_dest_addr),
    .in_src_addr     (in_src_addr),
    .in_arrival_port (in_arrival_port),
    .out_action      (out_action),
    .out_port        (out_port),
    .out_learned     (out_learned),
    .out_table_full  (out_table_full)
  );

endmodule

// File: verif/tb_learning_bridge_forwarder.sv
// Self-checking testbench for the two-port learning bridge forwarder.
`timescale 1ns / 1ps

module tb_learning_bridge_forwarder;

  localparam int ADDR_BITS = 48;
  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam logic [ADDR_BITS-1:0] BCAST_ADDR = '1;

  typedef struct packed {
    logic [1:0] action;
    logic       port;
    logic       learned;
    logic       full;
  } decision_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_BITS-1:0] in_dest_addr = '0;
  logic [ADDR_BITS-1:0] in_src_addr = '0;
  logic                 in_arrival_port = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_action;
  logic                 out_port;
  logic                 out_learned;
  logic                 out_table_full;

  logic [ADDR_BITS-1:0] station_addr [TABLE_DEPTH];
  logic                 station_port [TABLE_DEPTH];
  int                   stations_known = 0;
  decision_t            expected_decisions [$];
  int                   mismatches = 0;
  int                   cycle_count = 0;
  bit                   calm = 1'b0;

  learning_bridge_forwarder #(
    .ADDR_BITS  (ADDR_BITS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_dest_addr   (in_dest_addr),
    .in_src_addr    (in_src_addr),
    .in_arrival_port(in_arrival_port),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_port       (out_port),
    .out_learned    (out_learned),
    .out_table_full (out_table_full)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int find_station(input logic [ADDR_BITS-1:0] addr);
    for (int i = 0; i < stations_known; i++) begin
      if (station_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic decision_t forward_decision(input logic [ADDR_BITS-1:0] dst,
                                                 input logic [ADDR_BITS-1:0] src,
                                                 input logic port);
    decision_t d;
    int hit;
    d = '0;
    if (find_station(src) < 0) begin
      if (stations_known < TABLE_DEPTH) begin
        station_addr[stations_known] = src;
        station_port[stations_known] = port;
        stations_known++;
        d.learned = 1'b1;
      end else begin
        d.full = 1'b1;
      end
    end
    if (dst == BCAST_ADDR) begin
      d.action = lbf_pkg::ACT_BCAST;
    end else begin
      hit = find_station(dst);
      if (hit < 0) begin
        d.action = lbf_pkg::ACT_UNKNOWN;
      end else if (station_port[hit] == port) begin
        d.action = lbf_pkg::ACT_FILTER;
      end else begin
        d.action = lbf_pkg::ACT_FORWARD;
        d.port = station_port[hit];
      end
    end
    return d;
  endfunction

  function automatic logic [ADDR_BITS-1:0] fresh_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] known_addr();
    if (stations_known == 0) return fresh_addr();
    return station_addr[$urandom_range(stations_known - 1)];
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_dest();
    int r;
    logic [ADDR_BITS-1:0] one_hot;
    r = $urandom_range(99);
    one_hot = '0;
    one_hot[$urandom_range(ADDR_BITS - 1)] = 1'b1;
    if (r < 60) return known_addr();
    if (r < 70) return BCAST_ADDR;
    if (r < 74) return BCAST_ADDR ^ one_hot;
    return fresh_addr();
  endfunction

  task automatic send_frame(input logic [ADDR_BITS-1:0] dst,
                            input logic [ADDR_BITS-1:0] src,
                            input logic port);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dest_addr <= dst;
    in_src_addr <= src;
    in_arrival_port <= port;
    do @(posedge clk); while (in_stall);
    expected_decisions.push_back(forward_decision(dst, src, port));
  endtask

  task automatic send_random(input int count, input int fresh_pct);
    logic [ADDR_BITS-1:0] src;
    for (int i = 0; i < count; i++) begin
      src = ($urandom_range(99) < fresh_pct) ? fresh_addr() : known_addr();
      send_frame(pick_dest(), src, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_directed();
    send_frame(BCAST_ADDR, 48'h0, 1'b0);
    send_frame(48'h0, 48'hA5A5_5A5A_0F0F, 1'b1);
    send_frame(48'h0, 48'h0, 1'b0);
    send_frame(48'h0, 48'h0, 1'b1);
    send_frame(48'h1234_5678_9ABC, 48'h1234_5678_9ABC, 1'b1);
    send_frame(48'h1234_5678_9ABC, 48'h5555_5555_5555, 1'b0);
    send_frame(48'hA5A5_5A5A_0F0F, 48'hFFFF_FFFF_FFFE, 1'b0);
    send_frame(48'hFFFF_FFFF_FFFE, BCAST_ADDR, 1'b1);
    send_frame(BCAST_ADDR, BCAST_ADDR, 1'b0);
    send_frame(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 1'b1);
    send_frame(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0);
    send_frame(48'h7FFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b1);
  endtask

  task automatic test_random_learning();
    send_random(400, 20);
  endtask

  task automatic test_table_full();
    while (stations_known < TABLE_DEPTH) begin
      send_frame(pick_dest(), fresh_addr(), 1'($urandom_range(1)));
    end
    send_frame(station_addr[0], 48'h0BAD_0BAD_0BAD, 1'b1);
    send_frame(48'h0BAD_0BAD_0BAD, fresh_addr(), 1'b0);
    send_frame(BCAST_ADDR, fresh_addr(), 1'b1);
    send_frame(station_addr[TABLE_DEPTH-1], station_addr[0], 1'b0);
    send_frame(station_addr[TABLE_DEPTH-1], station_addr[1], 1'b1);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    send_random(150, 10);
    calm = 1'b0;
  endtask

  task automatic test_random_full();
    send_random(550, 15);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin : check_results
    decision_t got;
    decision_t want;
    got = {out_action, out_port, out_learned, out_table_full};
    if (rst_n && out_valid && !out_stall) begin
      if (expected_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: action %0d port %0d learned %0d full %0d",
                   got.action, got.port, got.learned, got.full);
      end else begin
        want = expected_decisions.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected action %0d port %0d learned %0d full %0d,",
                     want.action, want.port, want.learned, want.full,
                     " got %0d %0d %0d %0d",
                     got.action, got.port, got.learned, got.full);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("learning_bridge_forwarder regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_learning();
    test_table_full();
    test_back_to_back();
    test_random_full();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("learning_bridge_forwarder regression: pass");
    end else begin
      $display("learning_bridge_forwarder regression: fail");
    end
    $finish;
  end

endmodule
